// ===== hdl/bta_pkg.sv =====
// ----------------------------------------------------------------------------
// bta_pkg: shared types and constants of the boundary-tag allocator
// Request and result beats, request codes, controller states, datapath
// commands and the status bundle returned to the controller.
// ----------------------------------------------------------------------------
package bta_pkg;

	localparam int DEF_POOL_BYTES   = 4096;
	localparam int DEF_HEADER_BYTES = 12;

	// request codes
	localparam logic [1:0] REQ_ALLOC   = 2'd0;
	localparam logic [1:0] REQ_FREE    = 2'd1;
	localparam logic [1:0] REQ_REALLOC = 2'd2;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [11:0] req_addr;
		logic        req_addr_valid;
		logic [11:0] req_size;
	} req_t;

	typedef struct packed {
		logic [11:0] result_addr;
		logic        result_null;
		logic        copy_valid;
		logic [11:0] copy_src;
		logic [11:0] copy_dst;
		logic [11:0] copy_len;
	} res_t;

	typedef enum logic [4:0] {
		ST_INIT_L, ST_INIT_R, ST_INIT_M, ST_IDLE, ST_DISP,
		ST_A_INIT, ST_A_CHK, ST_A_EVAL,
		ST_SP_CHK, ST_SP_N, ST_SP_WSP, ST_SP_WC,
		ST_F_INIT, ST_F_CHK, ST_F_EVAL,
		ST_FR_RO, ST_FR_O, ST_FR_N, ST_FR_P, ST_FR_E,
		ST_RE_N0, ST_RE_N, ST_RE_P,
		ST_FAIL, ST_DONE
	} state_t;

	typedef enum logic [4:0] {
		OP_NOP, OP_INIT_L, OP_INIT_R, OP_INIT_M, OP_LATCH,
		OP_A_INIT, OP_RD_P, OP_A_EVAL,
		OP_RD_N, OP_SP_N, OP_SP_WSP, OP_SP_WC,
		OP_F_INIT, OP_F_EVAL,
		OP_RD_O, OP_FR_O, OP_FR_N, OP_FR_P, OP_FR_E,
		OP_RD_N2, OP_RE_N, OP_RE_P,
		OP_FAIL
	} op_t;

	typedef struct packed {
		logic is_alloc;
		logic is_free;
		logic is_realloc;
		logic addr_valid;
		logic walk_end;
		logic addr_low;
		logic past_tgt;
		logic at_tgt;
		logic fit;
		logic rd_free;
		logic need_split;
		logic fr_merge;
		logic grow;
		logic fallback;
	} status_t;

endpackage

// ===== hdl/bta_ram.sv =====
// ----------------------------------------------------------------------------
// bta_ram: generic single-port RAM
// One optional write and one read per cycle at one address, read data registered.
// ----------------------------------------------------------------------------
module bta_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ===== hdl/bta_datapath.sv =====
// ----------------------------------------------------------------------------
// bta_datapath: header store and chunk arithmetic
// Holds size, previous size and free mark in three RAMs sharing one address,
// the walk pointer and the chunk registers; executes one command a cycle.
// ----------------------------------------------------------------------------
module bta_datapath import bta_pkg::*; #(
	parameter int POOL_BYTES   = DEF_POOL_BYTES,
	parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
	input  logic    clk,
	input  logic    arst_n,
	input  op_t     op,
	input  req_t    req,
	output status_t status,
	output res_t    result
);

	localparam int POOL_AL = ((POOL_BYTES + 3) / 4) * 4;
	localparam int DEPTH   = POOL_AL / 4 + 1;
	localparam int IW      = $clog2(DEPTH);
	localparam int SW      = $clog2(POOL_AL - 3 * HEADER_BYTES + 2);
	localparam int WW      = ((IW + 2) > 14 ? IW + 2 : 14) + 1;
	localparam logic [WW-1:0] HDR    = WW'(HEADER_BYTES);
	localparam logic [WW-1:0] END_P  = WW'(POOL_AL - HEADER_BYTES);
	localparam logic [WW-1:0] MAIN_W = WW'(POOL_AL - 3 * HEADER_BYTES);

	// request and chunk registers
	logic [1:0]    typ_q;
	logic          av_q;
	logic [WW-1:0] addr_q, s_q, p_q, tgt_q, c_q, csz_q, o_q, osz_q, opv_q;
	logic [WW-1:0] n_q, nsz_q, pr_q, spsz_q, e_pos_q, e_val_q;
	logic [WW-1:0] res_q, cps_q, cpd_q, cpl_q;
	logic          nf_q, null_q, cpv_q, fb_q;

	// memory side
	logic [SW-1:0] rd_sz, rd_pv, wd_sz, wd_pv;
	logic          rd_fr, wd_fr, we_sz, we_pv, we_fr;
	logic [WW-1:0] pos, szw, pvw;
	logic [IW-1:0] idx;

	logic [WW-1:0] rsz, rpv, p_next, rest, cs, need;
	logic [13:0]   s_round;
	logic          fit, need_split, ca, cb, cc;

	assign rsz        = WW'(rd_sz);
	assign rpv        = WW'(rd_pv);
	assign p_next     = p_q + HDR + rsz;
	assign need       = s_q + HDR;
	assign fit        = rd_fr && (rsz >= s_q);
	assign need_split = csz_q > need;
	assign rest       = csz_q - need;
	assign cs         = nf_q ? osz_q + nsz_q + HDR : osz_q;
	assign ca         = osz_q > need;
	assign cb         = rd_fr && ((rsz + osz_q) >= need);
	assign cc         = nf_q && ((nsz_q + osz_q) >= need);
	assign s_round    = ({2'b00, req.req_size} + 14'd3) & ~14'd3;

	// status back to the controller
	always_comb begin
		status.is_alloc   = (typ_q == REQ_ALLOC) || ((typ_q == REQ_REALLOC) && !av_q);
		status.is_free    = typ_q == REQ_FREE;
		status.is_realloc = (typ_q == REQ_REALLOC) && av_q;
		status.addr_valid = av_q;
		status.walk_end   = p_q >= END_P;
		status.addr_low   = addr_q < (HDR + HDR);
		status.past_tgt   = p_q > tgt_q;
		status.at_tgt     = p_q == tgt_q;
		status.fit        = fit;
		status.rd_free    = rd_fr;
		status.need_split = need_split;
		status.fr_merge   = rd_fr || nf_q;
		status.grow       = ca || cb || cc;
		status.fallback   = fb_q;
	end

	// memory address and write data per command
	always_comb begin
		pos   = p_q;
		szw   = '0;
		pvw   = '0;
		wd_fr = 1'b0;
		we_sz = 1'b0;
		we_pv = 1'b0;
		we_fr = 1'b0;
		case (op)
			OP_INIT_L: begin
				pos = '0;
				{we_sz, we_pv, we_fr} = 3'b111;
			end
			OP_INIT_R: begin
				pos = END_P;
				pvw = MAIN_W;
				{we_sz, we_pv, we_fr} = 3'b111;
			end
			OP_INIT_M: begin
				pos   = HDR;
				szw   = MAIN_W;
				wd_fr = 1'b1;
				{we_sz, we_pv, we_fr} = 3'b111;
			end
			OP_RD_P: pos = p_q;
			OP_RD_O: pos = o_q;
			OP_RD_N: pos = c_q + HDR + csz_q;
			OP_SP_N: begin
				// next chunk free: the new remainder absorbs it
				we_pv = 1'b1;
				if (rd_fr) begin
					pos = n_q + HDR + rsz;
					pvw = rest + rsz + HDR;
				end else begin
					pos = n_q;
					pvw = rest;
				end
			end
			OP_SP_WSP: begin
				pos   = c_q + need;
				szw   = spsz_q;
				pvw   = s_q;
				wd_fr = 1'b1;
				{we_sz, we_pv, we_fr} = 3'b111;
			end
			OP_SP_WC: begin
				pos   = c_q;
				szw   = need_split ? s_q : csz_q;
				we_sz = 1'b1;
				we_fr = 1'b1;
			end
			OP_FR_O: pos = o_q + HDR + rsz;
			OP_FR_N: pos = o_q - opv_q - HDR;
			OP_FR_P: begin
				we_sz = 1'b1;
				if (rd_fr) begin
					pos = pr_q;
					szw = rsz + cs + HDR;
				end else begin
					pos   = o_q;
					szw   = cs;
					wd_fr = 1'b1;
					we_fr = 1'b1;
				end
			end
			OP_FR_E: begin
				pos   = e_pos_q;
				pvw   = e_val_q;
				we_pv = 1'b1;
			end
			OP_RD_N2: pos = o_q + HDR + osz_q;
			OP_RE_N: pos = o_q - opv_q - HDR;
			OP_RE_P: begin
				if (!ca && cb) begin
					pos   = n_q;
					pvw   = rsz + osz_q + HDR;
					we_pv = 1'b1;
				end else if (!ca && cc) begin
					pos   = n_q + HDR + nsz_q;
					pvw   = osz_q + nsz_q + HDR;
					we_pv = 1'b1;
				end
			end
			default: pos = p_q;
		endcase
	end

	assign idx   = pos[IW+1:2];
	assign wd_sz = szw[SW-1:0];
	assign wd_pv = pvw[SW-1:0];

	bta_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_size_ram (
		.clk(clk), .we(we_sz), .addr(idx), .wdata(wd_sz), .rdata(rd_sz)
	);
	bta_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_prev_ram (
		.clk(clk), .we(we_pv), .addr(idx), .wdata(wd_pv), .rdata(rd_pv)
	);
	bta_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_free_ram (
		.clk(clk), .we(we_fr), .addr(idx), .wdata(wd_fr), .rdata(rd_fr)
	);

	// register updates per command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			typ_q   <= '0;
			av_q    <= 1'b0;
			addr_q  <= '0;
			s_q     <= '0;
			p_q     <= '0;
			tgt_q   <= '0;
			c_q     <= '0;
			csz_q   <= '0;
			o_q     <= '0;
			osz_q   <= '0;
			opv_q   <= '0;
			n_q     <= '0;
			nsz_q   <= '0;
			pr_q    <= '0;
			spsz_q  <= '0;
			e_pos_q <= '0;
			e_val_q <= '0;
			res_q   <= '0;
			cps_q   <= '0;
			cpd_q   <= '0;
			cpl_q   <= '0;
			nf_q    <= 1'b0;
			null_q  <= 1'b0;
			cpv_q   <= 1'b0;
			fb_q    <= 1'b0;
		end else begin
			case (op)
				OP_LATCH: begin
					typ_q  <= req.req_type;
					av_q   <= req.req_addr_valid;
					addr_q <= WW'(req.req_addr);
					s_q    <= WW'(s_round);
					res_q  <= '0;
					null_q <= 1'b0;
					cpv_q  <= 1'b0;
					fb_q   <= 1'b0;
				end
				OP_A_INIT: p_q <= HDR;
				OP_A_EVAL: begin
					if (fit) begin
						c_q   <= p_q;
						csz_q <= rsz;
						res_q <= p_q + HDR;
						if (fb_q) begin
							cpv_q <= 1'b1;
							cpd_q <= p_q + HDR;
						end
					end else begin
						p_q <= p_next;
					end
				end
				OP_RD_N: n_q <= c_q + HDR + csz_q;
				OP_SP_N: spsz_q <= rd_fr ? rest + rsz + HDR : rest;
				OP_F_INIT: begin
					p_q   <= HDR;
					tgt_q <= addr_q - HDR;
				end
				OP_F_EVAL: begin
					if (p_q == tgt_q) begin
						o_q   <= p_q;
						osz_q <= rsz;
						opv_q <= rpv;
					end else begin
						p_q <= p_next;
					end
				end
				OP_FR_O: begin
					osz_q <= rsz;
					opv_q <= rpv;
					n_q   <= o_q + HDR + rsz;
				end
				OP_FR_N, OP_RE_N: begin
					nsz_q <= rsz;
					nf_q  <= rd_fr;
					pr_q  <= o_q - opv_q - HDR;
				end
				OP_FR_P: begin
					e_pos_q <= o_q + HDR + cs;
					e_val_q <= rd_fr ? rsz + cs + HDR : cs;
				end
				OP_RD_N2: n_q <= o_q + HDR + osz_q;
				OP_RE_P: begin
					if (ca) begin
						c_q   <= o_q;
						csz_q <= osz_q;
						res_q <= o_q + HDR;
					end else if (cb) begin
						// grow downward: payload moves to the previous chunk
						c_q   <= pr_q;
						csz_q <= rsz + osz_q + HDR;
						res_q <= pr_q + HDR;
						cpv_q <= 1'b1;
						cps_q <= o_q + HDR;
						cpd_q <= pr_q + HDR;
						cpl_q <= osz_q;
					end else if (cc) begin
						c_q   <= o_q;
						csz_q <= osz_q + nsz_q + HDR;
						res_q <= o_q + HDR;
					end else begin
						fb_q  <= 1'b1;
						cps_q <= o_q + HDR;
						cpl_q <= (osz_q < s_q) ? osz_q : s_q;
					end
				end
				OP_FAIL: begin
					null_q <= 1'b1;
					res_q  <= '0;
					cpv_q  <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// result beat
	always_comb begin
		result.result_addr = res_q[11:0];
		result.result_null = null_q;
		result.copy_valid  = cpv_q;
		result.copy_src    = cpv_q ? cps_q[11:0] : 12'd0;
		result.copy_dst    = cpv_q ? cpd_q[11:0] : 12'd0;
		result.copy_len    = cpv_q ? cpl_q[11:0] : 12'd0;
	end

endmodule

// ===== hdl/bta_ctrl.sv =====
// ----------------------------------------------------------------------------
// bta_ctrl: request sequencer
// Walks the chunk chain and steps through alloc, split, free and realloc,
// issuing one datapath command per cycle.
// ----------------------------------------------------------------------------
module bta_ctrl import bta_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  status_t status,
	output op_t     op,
	output logic    busy,
	output logic    done
);

	state_t state_q, state_nx;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT_L;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state and command
	always_comb begin
		state_nx = state_q;
		op       = OP_NOP;
		case (state_q)
			ST_INIT_L: begin
				op = OP_INIT_L;
				state_nx = ST_INIT_R;
			end
			ST_INIT_R: begin
				op = OP_INIT_R;
				state_nx = ST_INIT_M;
			end
			ST_INIT_M: begin
				op = OP_INIT_M;
				state_nx = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					op = OP_LATCH;
					state_nx = ST_DISP;
				end
			end
			ST_DISP: begin
				if (status.is_alloc) begin
					state_nx = ST_A_INIT;
				end else if (status.is_free) begin
					state_nx = status.addr_valid ? ST_F_INIT : ST_DONE;
				end else if (status.is_realloc) begin
					state_nx = ST_F_INIT;
				end else begin
					state_nx = ST_FAIL;
				end
			end
			// first-fit walk
			ST_A_INIT: begin
				op = OP_A_INIT;
				state_nx = ST_A_CHK;
			end
			ST_A_CHK: begin
				op = OP_RD_P;
				state_nx = status.walk_end ? ST_FAIL : ST_A_EVAL;
			end
			ST_A_EVAL: begin
				op = OP_A_EVAL;
				state_nx = status.fit ? ST_SP_CHK : ST_A_CHK;
			end
			// split of the chosen chunk
			ST_SP_CHK: begin
				op = OP_RD_N;
				state_nx = status.need_split ? ST_SP_N : ST_SP_WC;
			end
			ST_SP_N: begin
				op = OP_SP_N;
				state_nx = ST_SP_WSP;
			end
			ST_SP_WSP: begin
				op = OP_SP_WSP;
				state_nx = ST_SP_WC;
			end
			ST_SP_WC: begin
				op = OP_SP_WC;
				state_nx = status.fallback ? ST_FR_RO : ST_DONE;
			end
			// lookup of a used chunk by payload address
			ST_F_INIT: begin
				op = OP_F_INIT;
				if (status.addr_low) begin
					state_nx = status.is_free ? ST_DONE : ST_FAIL;
				end else begin
					state_nx = ST_F_CHK;
				end
			end
			ST_F_CHK: begin
				op = OP_RD_P;
				if (status.walk_end || status.past_tgt) begin
					state_nx = status.is_free ? ST_DONE : ST_FAIL;
				end else begin
					state_nx = ST_F_EVAL;
				end
			end
			ST_F_EVAL: begin
				op = OP_F_EVAL;
				if (!status.at_tgt) begin
					state_nx = ST_F_CHK;
				end else if (status.rd_free) begin
					state_nx = status.is_free ? ST_DONE : ST_FAIL;
				end else begin
					state_nx = status.is_free ? ST_FR_RO : ST_RE_N0;
				end
			end
			// free with merging
			ST_FR_RO: begin
				op = OP_RD_O;
				state_nx = ST_FR_O;
			end
			ST_FR_O: begin
				op = OP_FR_O;
				state_nx = ST_FR_N;
			end
			ST_FR_N: begin
				op = OP_FR_N;
				state_nx = ST_FR_P;
			end
			ST_FR_P: begin
				op = OP_FR_P;
				state_nx = status.fr_merge ? ST_FR_E : ST_DONE;
			end
			ST_FR_E: begin
				op = OP_FR_E;
				state_nx = ST_DONE;
			end
			// realloc: neighbors, then in place or fallback
			ST_RE_N0: begin
				op = OP_RD_N2;
				state_nx = ST_RE_N;
			end
			ST_RE_N: begin
				op = OP_RE_N;
				state_nx = ST_RE_P;
			end
			ST_RE_P: begin
				op = OP_RE_P;
				state_nx = status.grow ? ST_SP_CHK : ST_A_INIT;
			end
			ST_FAIL: begin
				op = OP_FAIL;
				state_nx = ST_DONE;
			end
			ST_DONE: begin
				state_nx = ST_IDLE;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	assign busy = state_q != ST_IDLE;
	assign done = state_q == ST_DONE;

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result beat outside a request");
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done)) else $error("accepted beat not in work");
	a_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");

endmodule

// ===== hdl/boundary_tag_first_fit_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// boundary_tag_first_fit_allocator_unit: first-fit heap allocator
// Alloc, free and realloc over a boundary-tag chunk chain; moves of payload
// are reported as copy commands.
//
//   channel  | handshake          | payload
//   request  | start, busy        | req    (req_t)
//   result   | done (one cycle)   | result (res_t)
//
// After reset the states INIT_L, INIT_R and INIT_M write the sentinels and the
// pool chunk; busy is high meanwhile. A request passes dispatch and setup,
// then a check and an evaluate state per chunk header walked (one registered
// read of the header store each), then the split writes or the free and merge
// writes. A realloc reads its neighbors in states RE_N0 and RE_N and decides in
// RE_P; a fallback adds a second walk plus split and free. The result beat is
// the done cycle, and busy drops the cycle after.
// ----------------------------------------------------------------------------
module boundary_tag_first_fit_allocator_unit import bta_pkg::*; #(
	parameter int POOL_BYTES   = DEF_POOL_BYTES,
	parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output res_t result
);

	op_t     op;
	status_t status;

	bta_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .status(status),
		.op(op), .busy(busy), .done(done)
	);

	bta_datapath #(.POOL_BYTES(POOL_BYTES), .HEADER_BYTES(HEADER_BYTES)) u_dp (
		.clk(clk), .arst_n(arst_n), .op(op), .req(req),
		.status(status), .result(result)
	);

endmodule

// ===== bench/boundary_tag_first_fit_allocator_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// boundary_tag_first_fit_allocator_unit_tb: self-checking bench of the allocator
// Drives alloc, free, realloc and unused-type requests against a behavioral
// copy of the chunk chain and compares every result beat field by field.
// ----------------------------------------------------------------------------
module boundary_tag_first_fit_allocator_unit_tb;
	import bta_pkg::*;

	localparam int HB       = DEF_HEADER_BYTES;
	localparam int POOL     = DEF_POOL_BYTES;
	localparam int END_POS  = POOL - HB;
	localparam int MAIN_SZ  = POOL - 3 * HB;
	localparam int DEPTH    = POOL / 4 + 1;
	localparam int WD_LIMIT = 20000;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	res_t result;

	boundary_tag_first_fit_allocator_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .done(done), .result(result)
	);

	// chunk chain model: size, previous size, free mark per 4-byte slot
	int unsigned hd_size [DEPTH];
	int unsigned hd_prev [DEPTH];
	bit          hd_free [DEPTH];
	bit          mv_valid;
	int unsigned mv_src, mv_dst, mv_len;

	req_t pending_reqs [$];
	res_t expected_results [$];
	int unsigned live_blocks [$];
	int errors;
	int accepted;
	int n_results;
	int idle_cycles;
	bit hold_off;
	bit calm;
	bit stim_done;

	function automatic int unsigned h_next(int unsigned p);
		return p + HB + hd_size[p >> 2];
	endfunction

	function automatic void hset(int unsigned p, int unsigned s, int unsigned pv, bit f);
		if ((p >> 2) < DEPTH) begin
			hd_size[p >> 2] = s;
			hd_prev[p >> 2] = pv;
			hd_free[p >> 2] = f;
		end
	endfunction

	function automatic void join_chunks(int unsigned l, int unsigned r);
		int unsigned after;
		int unsigned ls;
		after = h_next(r);
		ls = hd_size[l >> 2] + hd_size[r >> 2] + HB;
		hd_size[l >> 2] = ls;
		hd_prev[after >> 2] = ls;
		if (!hd_free[r >> 2]) begin
			mv_valid = 1;
			mv_src = r + HB;
			mv_dst = l + HB;
			mv_len = hd_size[r >> 2];
			hd_free[l >> 2] = 0;
		end
	endfunction

	function automatic void carve(int unsigned c, int unsigned s);
		int unsigned n;
		int unsigned rest;
		int unsigned sp;
		if (hd_size[c >> 2] <= s + HB) return;
		n = h_next(c);
		rest = hd_size[c >> 2] - s - HB;
		hd_size[c >> 2] = s;
		sp = c + HB + s;
		hset(sp, rest, s, 1);
		hd_prev[n >> 2] = rest;
		if (hd_free[n >> 2]) join_chunks(sp, n);
	endfunction

	function automatic bit first_fit(int unsigned s, output int unsigned addr);
		int unsigned p;
		p = HB;
		addr = 0;
		for (int k = 0; k < DEPTH && p < END_POS; k++) begin
			if (hd_free[p >> 2] && hd_size[p >> 2] >= s) begin
				carve(p, s);
				hd_free[p >> 2] = 0;
				addr = p + HB;
				return 1;
			end
			p = h_next(p);
		end
		return 0;
	endfunction

	function automatic bit locate_used(int unsigned addr, output int unsigned pos);
		int unsigned c;
		int unsigned p;
		pos = 0;
		if (addr < 2 * HB) return 0;
		c = addr - HB;
		p = HB;
		for (int k = 0; k < DEPTH && p < END_POS; k++) begin
			if (p == c) begin
				pos = c;
				return !hd_free[c >> 2];
			end
			if (p > c) return 0;
			p = h_next(p);
		end
		return 0;
	endfunction

	function automatic void release_chunk(int unsigned c);
		int unsigned pr;
		int unsigned n;
		pr = c - hd_prev[c >> 2] - HB;
		n = h_next(c);
		hd_free[c >> 2] = 1;
		if (hd_free[n >> 2]) join_chunks(c, n);
		if (hd_free[pr >> 2]) join_chunks(pr, c);
	endfunction

	function automatic void pool_reset();
		for (int i = 0; i < DEPTH; i++) hset(i * 4, 0, 0, 0);
		hset(0, 0, 0, 0);
		hset(END_POS, 0, MAIN_SZ, 0);
		hset(HB, MAIN_SZ, 0, 1);
	endfunction

	// predict one request's result beat and update the chain
	function automatic res_t allocator_step(req_t r);
		res_t o;
		int unsigned s, res, c, pr, n, old, need;
		bit fail;
		s = (int'(r.req_size) + 3) & ~3;
		res = 0;
		c = 0;
		fail = 0;
		mv_valid = 0;
		mv_src = 0;
		mv_dst = 0;
		mv_len = 0;
		if (r.req_type == REQ_ALLOC || (r.req_type == REQ_REALLOC && !r.req_addr_valid)) begin
			fail = !first_fit(s, res);
		end else if (r.req_type == REQ_FREE) begin
			if (r.req_addr_valid && locate_used(r.req_addr, c)) release_chunk(c);
		end else if (r.req_type == REQ_REALLOC) begin
			if (!locate_used(r.req_addr, c)) begin
				fail = 1;
			end else begin
				pr = c - hd_prev[c >> 2] - HB;
				n = h_next(c);
				old = hd_size[c >> 2];
				need = s + HB;
				if (old > need) begin
					carve(c, s);
					res = r.req_addr;
				end else if (hd_free[pr >> 2] && hd_size[pr >> 2] + old >= need) begin
					join_chunks(pr, c);
					carve(pr, s);
					res = pr + HB;
				end else if (hd_free[n >> 2] && hd_size[n >> 2] + old >= need) begin
					join_chunks(c, n);
					carve(c, s);
					res = r.req_addr;
				end else if (first_fit(s, res)) begin
					mv_valid = 1;
					mv_src = r.req_addr;
					mv_dst = res;
					mv_len = old < s ? old : s;
					release_chunk(c);
				end else begin
					fail = 1;
				end
			end
		end else begin
			fail = 1;
		end
		if (fail) res = 0;
		o.result_addr = res[11:0];
		o.result_null = fail;
		o.copy_valid  = mv_valid;
		o.copy_src    = mv_valid ? mv_src[11:0] : '0;
		o.copy_dst    = mv_valid ? mv_dst[11:0] : '0;
		o.copy_len    = mv_valid ? mv_len[11:0] : '0;
		return o;
	endfunction

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		$display("MISMATCH result %0d %s: got %0d expected %0d", n_results, what, got, want);
		errors++;
	endtask

	task automatic queue_req(logic [1:0] t, int unsigned a, bit av, int unsigned s);
		req_t r;
		r.req_type = t;
		r.req_addr = a[11:0];
		r.req_addr_valid = av;
		r.req_size = s[11:0];
		pending_reqs.push_back(r);
	endtask

	// clock
	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// request driver: prediction happens on acceptance; frees and reallocs
	// often take the address of a block handed out earlier
	always @(posedge clk or negedge arst_n) begin : drv
		req_t r;
		res_t e;
		int unsigned la;
		if (!arst_n) begin
			start <= 0;
			req <= '0;
		end else begin
			if (start && !busy) begin
				e = allocator_step(req);
				expected_results.push_back(e);
				accepted++;
				calm = (accepted >= 500 && accepted < 800);
				if (!e.result_null && e.result_addr != 12'd0)
					live_blocks.push_back({20'd0, e.result_addr});
			end
			if (start && busy) begin
				// hold the beat until it is taken
			end else if (pending_reqs.size() > 0 && !hold_off
					&& (calm || $urandom_range(99) >= 21)) begin
				r = pending_reqs.pop_front();
				if (r.req_type != REQ_ALLOC && live_blocks.size() > 0
						&& $urandom_range(9) < 7) begin
					la = live_blocks[$urandom_range(live_blocks.size() - 1)];
					r.req_addr = la[11:0];
				end
				start <= 1;
				req <= r;
			end else begin
				start <= 0;
			end
		end
	end

	// result monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				n_results++;
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected beat", result.result_addr, 0);
				end else begin
					res_t e;
					e = expected_results.pop_front();
					if (result.result_addr !== e.result_addr)
						report_mismatch("result_addr", result.result_addr, e.result_addr);
					if (result.result_null !== e.result_null)
						report_mismatch("result_null", result.result_null, e.result_null);
					if (result.copy_valid !== e.copy_valid)
						report_mismatch("copy_valid", result.copy_valid, e.copy_valid);
					if (result.copy_src !== e.copy_src)
						report_mismatch("copy_src", result.copy_src, e.copy_src);
					if (result.copy_dst !== e.copy_dst)
						report_mismatch("copy_dst", result.copy_dst, e.copy_dst);
					if (result.copy_len !== e.copy_len)
						report_mismatch("copy_len", result.copy_len, e.copy_len);
				end
			end
			if (done || (start && !busy)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= WD_LIMIT) begin
				$display("Watchdog expired after %0d idle cycles", WD_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// address and size mixes for random requests
	function automatic int unsigned pick_addr();
		int unsigned a;
		case ($urandom_range(9))
			0: a = $urandom_range(4095);
			1: a = HB * 2 + 4 * $urandom_range(20);
			default: a = $urandom_range(4095);
		endcase
		return a;
	endfunction

	function automatic int unsigned pick_size();
		case ($urandom_range(19))
			0: return $urandom_range(4095);
			1: return 0;
			2, 3, 4: return $urandom_range(400);
			default: return $urandom_range(120);
		endcase
	endfunction

	initial begin
		int unsigned a;
		int unsigned t;
		errors = 0;
		accepted = 0;
		n_results = 0;
		idle_cycles = 0;
		hold_off = 0;
		stim_done = 0;
		start = 0;
		req = '0;
		arst_n = 0;
		pool_reset();
		repeat (12) @(posedge clk);
		arst_n <= 0;
		@(negedge clk);
		arst_n = 1;

		// directed: field extremes, every request kind, special cases
		queue_req(REQ_ALLOC, 0, 0, 0);           // zero-sized block
		queue_req(REQ_ALLOC, 4095, 1, 1);
		queue_req(REQ_ALLOC, 0, 0, 4095);        // too large: null
		queue_req(REQ_ALLOC, 0, 0, 64);
		queue_req(REQ_FREE, 0, 0, 0);            // free without address
		queue_req(REQ_FREE, 5, 1, 0);            // not a block
		queue_req(REQ_FREE, 4095, 1, 4095);
		queue_req(REQ_REALLOC, 0, 0, 8);         // realloc as alloc
		queue_req(REQ_REALLOC, 3, 1, 8);         // bad address: null
		queue_req(REQ_REALLOC, 2 * HB, 1, 0);    // shrink/grow first block
		queue_req(REQ_FREE, 2 * HB, 1, 0);
		queue_req(REQ_UNUSED, 4095, 1, 4095);    // unused type
		queue_req(REQ_ALLOC, 0, 0, 100);
		queue_req(REQ_ALLOC, 0, 0, 100);
		queue_req(REQ_ALLOC, 0, 0, 100);
		queue_req(REQ_FREE, 2 * HB + 100 + HB + 4, 1, 0);
		queue_req(REQ_REALLOC, 0, 1, 2000);
		queue_req(REQ_ALLOC, 0, 0, 3000);
		queue_req(REQ_ALLOC, 0, 0, MAIN_SZ);

		// random: mostly frees/reallocs of likely block addresses
		for (int i = 0; i < 1200; i++) begin
			t = $urandom_range(99);
			a = pick_addr();
			if (t < 40) queue_req(REQ_ALLOC, $urandom_range(4095), 1'($urandom_range(1)),
				pick_size());
			else if (t < 65) queue_req(REQ_FREE, a, $urandom_range(9) != 0, $urandom_range(4095));
			else if (t < 97) queue_req(REQ_REALLOC, a, $urandom_range(9) != 0, pick_size());
			else queue_req(REQ_UNUSED, a, 1'($urandom_range(1)), $urandom_range(4095));
			if (i == 300) begin
				// pause until the block has drained
				while (pending_reqs.size() != 0) @(posedge clk);
				hold_off = 1;
				while (start || expected_results.size() != 0) @(posedge clk);
				hold_off = 0;
			end
		end
		while (pending_reqs.size() != 0 || start) @(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("Covered %0d requests (alloc, free, realloc, unused type) and %0d results.",
			accepted, n_results);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ===== boundary_tag_first_fit_allocator_unit.f =====
hdl/bta_pkg.sv
hdl/bta_ram.sv
hdl/bta_datapath.sv
hdl/bta_ctrl.sv
hdl/boundary_tag_first_fit_allocator_unit.sv
bench/boundary_tag_first_fit_allocator_unit_tb.sv
